/* hdl/astw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astw_pkg
// Types, constants and helpers shared by the text writer files.
// ----------------------------------------------------------------------------
package astw_pkg;

  localparam int MAX_PARAMS = 16;
  localparam int MAX_COLS   = 240;
  localparam int MAX_ROWS   = 80;
  localparam int PIDX_W     = $clog2(MAX_PARAMS);
  localparam int PARAM_W    = 16;

  localparam logic [7:0] MIN_COLS = 8'd20;
  localparam logic [6:0] MIN_ROWS = 7'd6;
  localparam logic [7:0] RST_COLS = 8'd120;
  localparam logic [6:0] RST_ROWS = 7'd40;
  localparam logic [7:0] TOP_COLS = 8'(MAX_COLS);
  localparam logic [6:0] TOP_ROWS = 7'(MAX_ROWS);

  localparam logic [9:0] CURSOR_TOP = 10'sd511;

  // characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] FINAL_LO = 8'h40;
  localparam logic [7:0] FINAL_HI = 8'h7E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // SGR codes
  localparam logic [15:0] SGR_RESET = 16'd0;
  localparam logic [15:0] SGR_BOLD  = 16'd1;
  localparam logic [15:0] SGR_DIM   = 16'd2;
  localparam logic [15:0] SGR_UNDER = 16'd4;
  localparam logic [15:0] SGR_REV   = 16'd7;
  localparam logic [15:0] SGR_FG_LO = 16'd30;
  localparam logic [15:0] SGR_FG_HI = 16'd37;
  localparam logic [15:0] SGR_FG_X  = 16'd38;
  localparam logic [15:0] SGR_BG_LO = 16'd40;
  localparam logic [15:0] SGR_BG_HI = 16'd47;
  localparam logic [15:0] SGR_BG_X  = 16'd48;
  localparam logic [15:0] SGR_FB_LO = 16'd90;
  localparam logic [15:0] SGR_FB_HI = 16'd97;
  localparam logic [15:0] SGR_BB_LO = 16'd100;
  localparam logic [15:0] SGR_BB_HI = 16'd107;
  localparam logic [15:0] SGR_SEL_RGB = 16'd2;
  localparam logic [15:0] SGR_SEL_IDX = 16'd5;

  localparam logic [7:0] ATTR_HEAVY = 8'h01;
  localparam logic [7:0] ATTR_FAINT = 8'h02;
  localparam logic [7:0] ATTR_UNDER = 8'h04;
  localparam logic [7:0] ATTR_REV   = 8'h08;

  localparam logic [15:0] COLOUR_DEF = 16'hFFFF;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    REQ_TEXT   = 3'd0,
    REQ_MOVE   = 3'd1,
    REQ_STYLE  = 3'd2,
    REQ_RSTYLE = 3'd3,
    REQ_CLEAR  = 3'd4,
    REQ_END    = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    PM_TEXT = 2'd0,
    PM_ESC  = 2'd1,
    PM_CSI  = 2'd2
  } pmode_t;

  typedef enum logic [2:0] {
    SG_NORM, SG_SEL, SG_IDX, SG_R, SG_G, SG_B
  } sgr_st_t;

  typedef struct packed {
    logic [15:0] fg;
    logic [15:0] bg;
    logic [7:0]  attr;
  } style_t;

  localparam logic OUT_CELL  = 1'b0;
  localparam logic OUT_CLEAR = 1'b1;

  function automatic logic [2:0] lead_len(input logic [7:0] c);
    if (!c[7])                  return 3'd1;
    if ((c & 8'hE0) == 8'hC0)   return 3'd2;
    if ((c & 8'hF0) == 8'hE0)   return 3'd3;
    if ((c & 8'hF8) == 8'hF0)   return 3'd4;
    return 3'd1;
  endfunction

  // colour cube level: saturate at 255 then c*6/256
  function automatic logic [2:0] cube(input logic [15:0] c);
    logic [7:0]  s;
    logic [10:0] p;
    s = (c > 16'd255) ? 8'hFF : c[7:0];
    p = 11'(s) * 11'd6;
    return p[10:8];
  endfunction

  function automatic logic [9:0] sat_inc(input logic [9:0] v);
    return (v == CURSOR_TOP) ? CURSOR_TOP : v + 10'd1;
  endfunction

endpackage

/* hdl/astw_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astw_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface astw_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic [7:0]        text_byte;
  logic signed [9:0] pos_x;
  logic signed [9:0] pos_y;
  logic signed [15:0] style_fg;
  logic signed [15:0] style_bg;
  logic [7:0]        style_attr;

  modport source (output valid, req_type, text_byte, pos_x, pos_y, style_fg,
                  style_bg, style_attr, input ready);
  modport sink   (input valid, req_type, text_byte, pos_x, pos_y, style_fg,
                  style_bg, style_attr, output ready);
endinterface

// ----------------------------------------------------------------------------
// astw_cell_if
// Result channel: cell writes and grid clears.
// ----------------------------------------------------------------------------
interface astw_cell_if;
  logic               valid;
  logic               ready;
  logic               out_kind;
  logic [7:0]         cell_x;
  logic [6:0]         cell_y;
  logic [31:0]        glyph_bytes;
  logic [2:0]         glyph_len;
  logic signed [15:0] cell_fg;
  logic signed [15:0] cell_bg;
  logic [7:0]         cell_attr;

  modport source (output valid, out_kind, cell_x, cell_y, glyph_bytes, glyph_len,
                  cell_fg, cell_bg, cell_attr, input ready);
  modport sink   (input valid, out_kind, cell_x, cell_y, glyph_bytes, glyph_len,
                  cell_fg, cell_bg, cell_attr, output ready);
endinterface

/* hdl/ansi_sgr_text_writer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_sgr_text_writer_unit
// Text writer with cursor, style and an ANSI SGR escape parser.
// ----------------------------------------------------------------------------
// Use:
//  in_if  : requests (text byte, move, set style, reset style, clear, end).
//  out_if : cell writes and grid clears, at most one per request.
//  cfg_*  : plain write port; index 0 screen width, index 1 screen height;
//           the user must write it only while the block is idle; not enforced.
// Timing:
//  A request is taken on a handshake; its result, if any, sits in the output
//  register from the next cycle on. Ordinary requests run at one per cycle
//  while the result side keeps up.
//  The SGR final byte 'm' walks the stored CSI parameters out of the
//  parameter RAM, one per cycle, with requests locked out until the walk and
//  its registered read data are done. The RAM's single read port sets this rate.
// Reset: cursor home, default style, parser in plain text, width 120 and
//  height 40. Parameter slots are cleared by a valid-bit vector.
// Stall: while a result waits untaken, no new request is taken.
// ----------------------------------------------------------------------------
module ansi_sgr_text_writer_unit
  import astw_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  astw_req_if.sink     in_if,
  astw_cell_if.source  out_if,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_wdata
);

  // configuration
  logic [7:0] width_r;
  logic [6:0] height_r;
  logic [7:0] effw;
  logic [6:0] effh;

  // parser and glyph state
  pmode_t            mode_r, mode_nxt;
  logic [PIDX_W-1:0] pidx_r, pidx_nxt;
  logic [15:0]       cur_param_r, cur_param_nxt;
  logic [MAX_PARAMS-1:0] pvld_r, pvld_nxt;
  logic [31:0]       gbuf_r, gbuf_nxt;
  logic [2:0]        gneed_r, gneed_nxt;
  logic [2:0]        gtot_r, gtot_nxt;
  logic [9:0]        col_r, col_nxt;
  logic [9:0]        row_r, row_nxt;
  style_t            sty_r, sty_nxt;

  // SGR walk
  logic              iss_r, iss_nxt;
  logic [PIDX_W-1:0] rd_addr_r, rd_addr_nxt;
  logic              d_vld_r;
  logic              d_last_r;
  logic [PIDX_W-1:0] d_addr_r;
  sgr_st_t           sg_r, sg_nxt;
  logic              ext_bg_r, ext_bg_nxt;
  logic              rgb_ok_r, rgb_ok_nxt;
  logic [2:0]        cr_r, cr_nxt;
  logic [2:0]        cg_r, cg_nxt;

  // parameter RAM
  logic              ram_we;
  logic [15:0]       ram_rdata;

  // output register
  logic        ov_r, ov_nxt;
  logic        okind_r, okind_nxt;
  logic [7:0]  ox_r, ox_nxt;
  logic [6:0]  oy_r, oy_nxt;
  logic [31:0] ogb_r, ogb_nxt;
  logic [2:0]  olen_r, olen_nxt;
  style_t      osty_r, osty_nxt;

  logic busy;
  logic acc;

  assign effw = (width_r < MIN_COLS) ? MIN_COLS :
                (width_r > TOP_COLS) ? TOP_COLS : width_r;
  assign effh = (height_r < MIN_ROWS) ? MIN_ROWS :
                (height_r > TOP_ROWS) ? TOP_ROWS : height_r;

  assign busy        = iss_r || d_vld_r;
  assign in_if.ready = rst_n && !busy && (!ov_r || out_if.ready);
  assign acc         = in_if.valid && in_if.ready;

  astw_ram #(.WIDTH(PARAM_W), .DEPTH(MAX_PARAMS)) u_params (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pidx_r),
    .wdata (cur_param_nxt),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // one plain SGR code
  function automatic style_t apply_code(input logic [15:0] v, input style_t s);
    style_t o;
    o = s;
    if (v == SGR_RESET) begin
      o.fg = COLOUR_DEF; o.bg = COLOUR_DEF; o.attr = 8'h00;
    end else if (v == SGR_BOLD)  o.attr = s.attr | ATTR_HEAVY;
    else if (v == SGR_DIM)       o.attr = s.attr | ATTR_FAINT;
    else if (v == SGR_UNDER)     o.attr = s.attr | ATTR_UNDER;
    else if (v == SGR_REV)       o.attr = s.attr | ATTR_REV;
    else if (v >= SGR_FG_LO && v <= SGR_FG_HI) o.fg = v - SGR_FG_LO;
    else if (v >= SGR_BG_LO && v <= SGR_BG_HI) o.bg = v - SGR_BG_LO;
    else if (v >= SGR_FB_LO && v <= SGR_FB_HI) o.fg = v - SGR_FB_LO + 16'd8;
    else if (v >= SGR_BB_LO && v <= SGR_BB_HI) o.bg = v - SGR_BB_LO + 16'd8;
    return o;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic        fall;
    logic        emit;
    logic        norm;
    logic [15:0] v;
    logic [19:0] prod;
    logic [2:0]  ll;
    logic [5:0]  pos;
    logic [15:0] rgb;

    mode_nxt      = mode_r;
    pidx_nxt      = pidx_r;
    cur_param_nxt = cur_param_r;
    pvld_nxt      = pvld_r;
    gbuf_nxt      = gbuf_r;
    gneed_nxt     = gneed_r;
    gtot_nxt      = gtot_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    sty_nxt       = sty_r;
    iss_nxt       = iss_r;
    rd_addr_nxt   = rd_addr_r;
    sg_nxt        = sg_r;
    ext_bg_nxt    = ext_bg_r;
    rgb_ok_nxt    = rgb_ok_r;
    cr_nxt        = cr_r;
    cg_nxt        = cg_r;
    ram_we        = 1'b0;
    ov_nxt        = ov_r && !out_if.ready;
    okind_nxt     = okind_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    ogb_nxt       = ogb_r;
    olen_nxt      = olen_r;
    osty_nxt      = osty_r;
    b             = in_if.text_byte;
    fall          = 1'b0;
    emit          = 1'b0;
    norm          = 1'b0;
    v             = pvld_r[d_addr_r] ? ram_rdata : 16'd0;
    prod          = 20'(cur_param_r) * 20'd10 + 20'(b - CH_0);
    ll            = lead_len(b);
    pos           = 6'(d_addr_r);
    rgb           = 16'd16 + 16'(cr_r) * 16'd36 + 16'(cg_r) * 16'd6 + 16'(cube(v));

    // parameter walk: issue side
    if (iss_r) begin
      if (rd_addr_r == pidx_r) iss_nxt = 1'b0;
      else rd_addr_nxt = rd_addr_r + 1'b1;
    end

    // parameter walk: data side
    if (d_vld_r) begin
      case (sg_r)
        SG_NORM: norm = 1'b1;
        SG_SEL: begin
          if (v == SGR_SEL_RGB && rgb_ok_r) sg_nxt = SG_R;
          else if (v == SGR_SEL_IDX) sg_nxt = SG_IDX;
          else norm = 1'b1;
        end
        SG_IDX: begin
          if (ext_bg_r) sty_nxt.bg = v; else sty_nxt.fg = v;
          sg_nxt = SG_NORM;
        end
        SG_R: begin cr_nxt = cube(v); sg_nxt = SG_G; end
        SG_G: begin cg_nxt = cube(v); sg_nxt = SG_B; end
        SG_B: begin
          if (ext_bg_r) sty_nxt.bg = rgb; else sty_nxt.fg = rgb;
          sg_nxt = SG_NORM;
        end
        default: sg_nxt = SG_NORM;
      endcase
      if (norm) begin
        sg_nxt = SG_NORM;
        if ((v == SGR_FG_X || v == SGR_BG_X) && (pos + 6'd2 <= 6'(pidx_r))) begin
          ext_bg_nxt = (v == SGR_BG_X);
          rgb_ok_nxt = (pos + 6'd4 <= 6'(pidx_r));
          sg_nxt     = SG_SEL;
        end else begin
          sty_nxt = apply_code(v, sty_r);
        end
      end
    end

    if (acc) begin
      case (req_t'(in_if.req_type))
        REQ_TEXT: begin
          if (mode_r == PM_CSI) begin
            if (b >= FINAL_LO && b <= FINAL_HI) begin
              mode_nxt = PM_TEXT;
              if (b == CH_M) begin
                iss_nxt     = 1'b1;
                rd_addr_nxt = '0;
                sg_nxt      = SG_NORM;
              end
            end else if (b >= CH_0 && b <= CH_9) begin
              cur_param_nxt    = (prod > 20'hFFFF) ? 16'hFFFF : prod[15:0];
              ram_we           = 1'b1;
              pvld_nxt[pidx_r] = 1'b1;
            end else if (b == CH_SEMI) begin
              if (pidx_r != PIDX_W'(MAX_PARAMS - 1)) begin
                pidx_nxt      = pidx_r + 1'b1;
                cur_param_nxt = 16'd0;
              end
            end
          end else if (mode_r == PM_ESC) begin
            mode_nxt = PM_TEXT;
            if (b == CH_LBR) begin
              mode_nxt      = PM_CSI;
              pvld_nxt      = '0;
              pidx_nxt      = '0;
              cur_param_nxt = 16'd0;
            end else begin
              fall = 1'b1;
            end
          end else begin
            fall = 1'b1;
          end

          if (fall) begin
            if (gneed_r != 3'd0) begin
              gbuf_nxt  = gbuf_r | (32'(b) << {gtot_r[1:0], 3'b000});
              gtot_nxt  = gtot_r + 3'd1;
              gneed_nxt = gneed_r - 3'd1;
              emit      = (gneed_r == 3'd1);
            end else if (b == CH_LF) begin
              row_nxt = sat_inc(row_r);
            end else if (b == CH_CR) begin
              // ignored
            end else if (b == CH_ESC) begin
              mode_nxt = PM_ESC;
            end else begin
              gbuf_nxt  = 32'(b);
              gtot_nxt  = 3'd1;
              gneed_nxt = ll - 3'd1;
              emit      = (ll == 3'd1);
            end
          end

          if (emit) begin
            if (!col_r[9] && (col_r[8:0] < 9'(effw)) &&
                !row_r[9] && (row_r[8:0] < 9'(effh))) begin
              ov_nxt    = 1'b1;
              okind_nxt = OUT_CELL;
              ox_nxt    = col_r[7:0];
              oy_nxt    = row_r[6:0];
              ogb_nxt   = gbuf_nxt;
              olen_nxt  = gtot_nxt;
              osty_nxt  = sty_r;
            end
            col_nxt   = sat_inc(col_r);
            gbuf_nxt  = 32'd0;
            gtot_nxt  = 3'd0;
            gneed_nxt = 3'd0;
          end
        end
        REQ_MOVE: begin
          col_nxt = in_if.pos_x;
          row_nxt = in_if.pos_y;
        end
        REQ_STYLE: begin
          sty_nxt.fg   = in_if.style_fg;
          sty_nxt.bg   = in_if.style_bg;
          sty_nxt.attr = in_if.style_attr;
        end
        REQ_RSTYLE: begin
          sty_nxt.fg = COLOUR_DEF; sty_nxt.bg = COLOUR_DEF; sty_nxt.attr = 8'h00;
        end
        REQ_CLEAR: begin
          col_nxt       = 10'd0;
          row_nxt       = 10'd0;
          ov_nxt        = 1'b1;
          okind_nxt     = OUT_CLEAR;
          ox_nxt        = 8'd0;
          oy_nxt        = 7'd0;
          ogb_nxt       = 32'(CH_SPACE);
          olen_nxt      = 3'd1;
          osty_nxt.fg   = COLOUR_DEF;
          osty_nxt.bg   = COLOUR_DEF;
          osty_nxt.attr = 8'h00;
        end
        REQ_END: begin
          mode_nxt  = PM_TEXT;
          gbuf_nxt  = 32'd0;
          gneed_nxt = 3'd0;
          gtot_nxt  = 3'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_COLS;
      height_r <= RST_ROWS;
      mode_r   <= PM_TEXT;
      pidx_r   <= '0;
      cur_param_r <= 16'd0;
      pvld_r   <= '0;
      gbuf_r   <= 32'd0;
      gneed_r  <= 3'd0;
      gtot_r   <= 3'd0;
      col_r    <= 10'd0;
      row_r    <= 10'd0;
      sty_r    <= '{fg: COLOUR_DEF, bg: COLOUR_DEF, attr: 8'h00};
      iss_r    <= 1'b0;
      rd_addr_r <= '0;
      d_vld_r  <= 1'b0;
      d_last_r <= 1'b0;
      sg_r     <= SG_NORM;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) width_r <= cfg_wdata;
        else height_r <= cfg_wdata[6:0];
      end
      mode_r      <= mode_nxt;
      pidx_r      <= pidx_nxt;
      cur_param_r <= cur_param_nxt;
      pvld_r      <= pvld_nxt;
      gbuf_r      <= gbuf_nxt;
      gneed_r     <= gneed_nxt;
      gtot_r      <= gtot_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      sty_r       <= sty_nxt;
      iss_r       <= iss_nxt;
      rd_addr_r   <= rd_addr_nxt;
      d_vld_r     <= iss_r;
      d_last_r    <= iss_r && (rd_addr_r == pidx_r);
      sg_r        <= sg_nxt;
      ov_r        <= ov_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    d_addr_r <= rd_addr_r;
    ext_bg_r <= ext_bg_nxt;
    rgb_ok_r <= rgb_ok_nxt;
    cr_r     <= cr_nxt;
    cg_r     <= cg_nxt;
    okind_r  <= okind_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    ogb_r    <= ogb_nxt;
    olen_r   <= olen_nxt;
    osty_r   <= osty_nxt;
  end

  assign out_if.valid       = ov_r;
  assign out_if.out_kind    = okind_r;
  assign out_if.cell_x      = ox_r;
  assign out_if.cell_y      = oy_r;
  assign out_if.glyph_bytes = ogb_r;
  assign out_if.glyph_len   = olen_r;
  assign out_if.cell_fg     = osty_r.fg;
  assign out_if.cell_bg     = osty_r.bg;
  assign out_if.cell_attr   = osty_r.attr;

  // no request is taken while the parameter walk runs
  a_walk_lock: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_if.ready) else $error("request taken during SGR walk");

  // the last walked parameter follows the issue of the last address
  a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
    d_last_r |-> (d_vld_r && !iss_r)) else $error("walk end out of step");

  // inside a CSI sequence no glyph is half collected
  a_csi_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == PM_CSI) |-> (gneed_r == 3'd0)) else $error("glyph open in CSI");

  // a cell write always lands inside the screen
  a_cell_in: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && okind_r == OUT_CELL) |-> (ox_r < effw && oy_r < effh))
    else $error("cell write off screen");

endmodule

/* hdl/astw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astw_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module astw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
